@@ hw/rtl/sswe_pkg.sv @@
package sswe_pkg;

	// pipeline depth, input register through result register
	localparam int NumStages = 9;

	typedef logic [3:0] digit_t;
	typedef logic [7:0] seg_t;
	typedef logic [5:0][3:0] digits_t;

	// segment positions inside seg_t
	localparam int SegA  = 0;
	localparam int SegB  = 1;
	localparam int SegC  = 2;
	localparam int SegD  = 3;
	localparam int SegE  = 4;
	localparam int SegF  = 5;
	localparam int SegG  = 6;
	localparam int SegDp = 7;

	localparam logic HeaterReset = 1'b1;

	// value / 1000000 = (value >> 6) / 15625, exact for 26-bit operands
	localparam int          ModShift      = 6;
	localparam logic [26:0] ModRecip      = 27'd70368745;
	localparam int          ModRecipShift = 40;
	localparam logic [19:0] DispModulus   = 20'd1000000;

	// x / 1000 for x < 2^20
	localparam logic [20:0] KiloRecip      = 21'd1073742;
	localparam int          KiloRecipShift = 30;
	localparam logic [9:0]  Kilo           = 10'd1000;

	// x / 100 for x < 2^10
	localparam logic [10:0] HundRecip      = 11'd1311;
	localparam int          HundRecipShift = 17;
	localparam logic [6:0]  Hundred        = 7'd100;

	// x / 10 for x < 2^7
	localparam logic [7:0] TenRecip      = 8'd205;
	localparam int         TenRecipShift = 11;
	localparam logic [3:0] Ten           = 4'd10;

	// seven-segment table, bit 0 = A ... bit 6 = G, decimal point always off
	function automatic seg_t seg7(digit_t d);
		seg_t s;
		case (d)
			4'd0: s = 8'h3F;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5B;
			4'd3: s = 8'h4F;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6D;
			4'd6: s = 8'h7D;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7F;
			4'd9: s = 8'h6F;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

@@ hw/rtl/sswe_word_pack.sv @@
module sswe_word_pack (
	input  sswe_pkg::digits_t digits,
	input  logic              heater,
	output logic [63:0]       word
);
	import sswe_pkg::*;

	seg_t s [6];

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			s[i] = seg7(digits[i]);
		end

		word = '0;

		// hundreds digit, split across the low driver halves
		word[0]  = s[2][SegB];
		word[1]  = s[2][SegDp];
		word[2]  = s[2][SegC];
		word[27] = s[2][SegD];
		word[28] = s[2][SegE];
		word[29] = s[2][SegF];
		word[30] = s[2][SegG];
		word[31] = s[2][SegA];

		word[3]  = s[1][SegD];
		word[4]  = s[1][SegE];
		word[5]  = s[1][SegF];
		word[6]  = s[1][SegG];
		word[10] = s[1][SegA];
		word[11] = s[1][SegB];
		word[12] = s[1][SegDp];
		word[13] = s[1][SegC];

		word[14] = s[0][SegD];
		word[15] = s[0][SegE];
		word[16] = s[0][SegF];
		word[17] = s[0][SegG];
		word[18] = s[0][SegA];
		word[19] = s[0][SegB];
		word[20] = s[0][SegDp];
		word[21] = s[0][SegC];

		word[32] = s[5][SegB];
		word[33] = s[5][SegDp];
		word[34] = s[5][SegC];
		word[59] = s[5][SegD];
		word[60] = s[5][SegE];
		word[61] = s[5][SegF];
		word[62] = s[5][SegG];
		word[63] = s[5][SegA];

		word[35] = s[4][SegD];
		word[36] = s[4][SegE];
		word[37] = s[4][SegF];
		word[38] = s[4][SegG];
		word[42] = s[4][SegA];
		word[43] = s[4][SegB];
		word[44] = s[4][SegDp];
		word[45] = s[4][SegC];

		word[46] = s[3][SegD];
		word[47] = s[3][SegE];
		word[48] = s[3][SegF];
		word[49] = s[3][SegG];
		word[50] = s[3][SegA];
		word[51] = s[3][SegB];
		word[52] = s[3][SegDp];
		word[53] = s[3][SegC];

		word[58] = heater;
	end

endmodule

@@ hw/rtl/six_digit_segment_word_encoder_core.sv @@
// the result passes through 9 register stages, input register through result register
// throughput: one transaction per cycle unless the output stalls; the reciprocal
//   multiply divider chain is fully pipelined, one constant multiply per stage and lane
// stalled results hold in place; empty stages still fill while the output waits
// reset (arst_n low, asynchronous): pipeline emptied, heater bit set to 1
module six_digit_segment_word_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] time_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] driver_word
);
	import sswe_pkg::*;

	logic [NumStages-1:0] vld_q;
	logic [NumStages-1:0] en;
	logic                 heater_q;

	logic [31:0] v_s1;
	logic [31:0] v_s2;
	logic [12:0] q_s2;
	logic [19:0] r_s3;
	logic [19:0] r_s4;
	logic [9:0]  hi_s4;
	logic [9:0]  x_s5   [2];
	logic [9:0]  x_s6   [2];
	digit_t      hund_s6 [2];
	digit_t      hund_s7 [2];
	digit_t      hund_s8 [2];
	logic [6:0]  rem_s7 [2];
	logic [6:0]  rem_s8 [2];
	digit_t      tens_s8 [2];
	logic [63:0] word_q;

	logic [52:0] q_prod;
	logic [31:0] r_full;
	logic [40:0] k_prod;
	logic [19:0] lo_full;
	logic [20:0] h_prod   [2];
	logic [9:0]  rem_full [2];
	logic [14:0] t_prod   [2];
	logic [6:0]  one_full [2];
	digits_t     digits;
	logic [63:0] word;

	// a stage loads when it is empty or its contents move on
	always_comb begin
		en[NumStages-1] = !vld_q[NumStages-1] || out_ready;
		for (int i = NumStages - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign in_ready    = en[0];
	assign out_valid   = vld_q[NumStages-1];
	assign driver_word = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			heater_q <= HeaterReset;
		end else begin
			if (cfg_wr_en) begin
				heater_q <= cfg_wr_data;
			end
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NumStages; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	always_comb begin
		q_prod  = 53'(v_s1[31:ModShift]) * 53'(ModRecip);
		r_full  = v_s2 - 32'(q_s2) * 32'(DispModulus);
		k_prod  = 41'(r_s3) * 41'(KiloRecip);
		lo_full = r_s4 - 20'(hi_s4) * 20'(Kilo);
		// lane 0 carries the low three digits, lane 1 the high three
		for (int i = 0; i < 2; i++) begin
			h_prod[i]   = 21'(x_s5[i]) * 21'(HundRecip);
			rem_full[i] = x_s6[i] - 10'(hund_s6[i]) * 10'(Hundred);
			t_prod[i]   = 15'(rem_s7[i]) * 15'(TenRecip);
			one_full[i] = rem_s8[i] - 7'(tens_s8[i]) * 7'(Ten);
			digits[3*i]     = one_full[i][3:0];
			digits[3*i + 1] = tens_s8[i];
			digits[3*i + 2] = hund_s8[i];
		end
	end

	sswe_word_pack u_word_pack (
		.digits (digits),
		.heater (heater_q),
		.word   (word)
	);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			v_s1 <= time_value;
		end
		if (en[1]) begin
			q_s2 <= q_prod[ModRecipShift+12:ModRecipShift];
			v_s2 <= v_s1;
		end
		if (en[2]) begin
			r_s3 <= r_full[19:0];
		end
		if (en[3]) begin
			hi_s4 <= k_prod[KiloRecipShift+9:KiloRecipShift];
			r_s4  <= r_s3;
		end
		if (en[4]) begin
			x_s5[0] <= lo_full[9:0];
			x_s5[1] <= hi_s4;
		end
		for (int i = 0; i < 2; i++) begin
			if (en[5]) begin
				hund_s6[i] <= h_prod[i][HundRecipShift+3:HundRecipShift];
				x_s6[i]    <= x_s5[i];
			end
			if (en[6]) begin
				rem_s7[i]  <= rem_full[i][6:0];
				hund_s7[i] <= hund_s6[i];
			end
			if (en[7]) begin
				tens_s8[i] <= t_prod[i][TenRecipShift+3:TenRecipShift];
				rem_s8[i]  <= rem_s7[i];
				hund_s8[i] <= hund_s7[i];
			end
		end
		if (en[8]) begin
			word_q <= word;
		end
	end

endmodule

@@ hw/rtl/sswe_checker.sv @@
module sswe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_wr_en,
	input logic        cfg_wr_data,
	input logic        in_valid,
	input logic        in_ready,
	input logic [31:0] time_value,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] driver_word
);
	import sswe_pkg::*;

	// unused positions and decimal points
	localparam logic [63:0] DarkMask = 64'h03D0_1382_07D0_1382;

	logic heater_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heater_q <= HeaterReset;
		end else if (cfg_wr_en) begin
			heater_q <= cfg_wr_data;
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(time_value))
		else $error("input transaction changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(driver_word))
		else $error("result changed while stalled");

	a_dark_bits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (driver_word & DarkMask) == 64'd0)
		else $error("unused or decimal point bit set");

	a_heater: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> driver_word[58] == heater_q)
		else $error("heater bit does not follow register");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind six_digit_segment_word_encoder_core sswe_checker u_sswe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_wr_en   (cfg_wr_en),
	.cfg_wr_data (cfg_wr_data),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.time_value  (time_value),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.driver_word (driver_word)
);

@@ verif/sswe_word_checker.sv @@
module sswe_word_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] time_value,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] driver_word,
	output int unsigned mismatch_count,
	output int unsigned words_pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import sswe_pkg::*;

	localparam int unsigned MaxReported = 10;

	typedef struct {
		logic [31:0] value;
		logic [63:0] word;
	} shown_word_t;

	// lit segments per digit, bit 0 = A ... bit 6 = G
	localparam seg_t DigitSegs [10] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
	};

	logic        heater_q;
	shown_word_t expected_words [$];

	// segments in the order the driver word lists them: D,E,F,G,A,B,DP,C
	function automatic logic [7:0] driver_order(seg_t s);
		return {s[SegC], s[SegDp], s[SegB], s[SegA], s[SegG], s[SegF], s[SegE], s[SegD]};
	endfunction

	function automatic logic [63:0] encode_driver_word(logic [31:0] value, logic heater);
		logic [7:0]  digit_bits [6];
		logic [63:0] w;
		int unsigned rest;
		rest = value % 32'(DispModulus);
		for (int i = 0; i < 6; i++) begin
			digit_bits[i] = driver_order(DigitSegs[rest % 10]);
			rest = rest / 10;
		end
		w = '0;
		w[2:0]   = digit_bits[2][7:5];
		w[6:3]   = digit_bits[1][3:0];
		w[13:10] = digit_bits[1][7:4];
		w[21:14] = digit_bits[0];
		w[31:27] = digit_bits[2][4:0];
		w[34:32] = digit_bits[5][7:5];
		w[38:35] = digit_bits[4][3:0];
		w[45:42] = digit_bits[4][7:4];
		w[53:46] = digit_bits[3];
		w[58]    = heater;
		w[63:59] = digit_bits[5][4:0];
		return w;
	endfunction

	initial begin
		mismatch_count = 0;
		words_pending = 0;
		heater_q = HeaterReset;
	end

	always @(posedge clk or negedge arst_n) begin
		shown_word_t oldest;
		if (!arst_n) begin
			heater_q = HeaterReset;
			expected_words.delete();
			words_pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MaxReported)
						$display("%0t: unexpected driver word %h", $realtime, driver_word);
				end else begin
					oldest = expected_words.pop_front();
					if (driver_word !== oldest.word) begin
						mismatch_count++;
						if (mismatch_count <= MaxReported)
							$display("%0t: value %0d expected %h got %h", $realtime,
								oldest.value, oldest.word, driver_word);
					end
				end
			end
			if (cfg_wr_en)
				heater_q = cfg_wr_data;
			if (in_valid && in_ready)
				expected_words.push_back('{value: time_value,
					word: encode_driver_word(time_value, heater_q)});
			words_pending = expected_words.size();
		end
	end

endmodule

@@ verif/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sswe_pkg::*;

	localparam int unsigned PhaseItems    = 325;
	localparam int unsigned RandomPhases  = 6;
	localparam int unsigned HoldOffCycles = 200;
	localparam int unsigned WatchdogLimit = 4000;
	localparam int unsigned Million       = 1000000;

	localparam logic [31:0] DirectedValues [20] = '{
		32'd0, 32'd1, 32'd9, 32'd10, 32'd99999, 32'd100000, 32'd999999, 32'd1000000,
		32'd1000001, 32'd1999999, 32'd123456, 32'd789012, 32'd345678, 32'd901234,
		32'd888888, 32'hFFFFFFFF, 32'h80000000, 32'hAAAAAAAA, 32'h55555555,
		32'd4294000000
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] time_value;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] driver_word;

	int unsigned mismatch_count;
	int unsigned words_pending;
	int unsigned idle_cycles;
	bit          tx_steady;
	bit          rx_steady;
	bit          hold_off_req;

	six_digit_segment_word_encoder_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.time_value (time_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.driver_word(driver_word)
	);

	sswe_word_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.time_value    (time_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.driver_word   (driver_word),
		.mismatch_count(mismatch_count),
		.words_pending (words_pending)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		in_valid = 1'b0;
		time_value = '0;
		out_ready = 1'b0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		hold_off_req = 1'b0;
	end

	always #6 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_time_value();
		int unsigned kind;
		logic [31:0] base;
		kind = $urandom_range(0, 9);
		base = 32'($urandom_range(0, 4293)) * 32'(Million);
		if (kind < 4)
			return $urandom;
		else if (kind < 7)
			return $urandom_range(0, Million - 1);
		else if (kind == 7)
			return base + $urandom_range(0, 3);
		else if (kind == 8)
			return base + (Million - 1) - $urandom_range(0, 3);
		else
			return $urandom_range(32'd4294000000, 32'hFFFFFFFF);
	endfunction

	// called just after a rising edge; returns just after the accepting edge
	task automatic send_value(input logic [31:0] value);
		int unsigned gap;
		bit          rdy;
		gap = tx_steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		time_value <= value;
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
	endtask

	// sender pauses until every expected word has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (words_pending != 0);
		@(posedge clk);
	endtask

	task automatic write_heater(input logic on);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= on;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// receiver: random stalls, steady stretches, and one long hold-off on request
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HoldOffCycles) @(posedge clk);
				hold_off_req = 1'b0;
				out_ready <= 1'b1;
			end else if (rx_steady || $urandom_range(0, 99) < 60) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				repeat (pick_gap()) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		idle_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// heater still at its reset value here
		foreach (DirectedValues[i])
			send_value(DirectedValues[i]);

		for (int p = 0; p < RandomPhases; p++) begin
			wait_drained();
			write_heater(p[0]);
			tx_steady = (p == 1 || p == 2);
			rx_steady = (p == 2);
			// long receiver hold-off while the sender keeps offering
			if (p == 1)
				hold_off_req = 1'b1;
			for (int i = 0; i < PhaseItems; i++)
				send_value(pick_time_value());
		end

		tx_steady = 1'b0;
		rx_steady = 1'b0;
		wait_drained();
		repeat (NumStages + 8) @(posedge clk);
		if (mismatch_count == 0 && words_pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/sswe_pkg.sv
hw/rtl/sswe_word_pack.sv
hw/rtl/six_digit_segment_word_encoder_core.sv
hw/rtl/sswe_checker.sv
verif/sswe_word_checker.sv
verif/tb_top.sv
